[rtl/smis_pkg.sv]
// Shared types and constants for the stack-machine instruction step block.
// Holds opcode, ALU function, error and sequencer state encodings.
// No dependencies; every rtl file refers to it by scoped names.
package smis_pkg;

    // Fixed widths of the transaction fields.
    localparam int WORD_W    = 32;
    localparam int PC_OUT_W  = 9;
    localparam int PTR_OUT_W = 11;

    // Number of defined ALU functions (0 .. ALU_FN_COUNT-1).
    localparam int ALU_FN_COUNT = 14;

    typedef enum logic [3:0] {
        OP_LIT   = 4'd1,
        OP_OPR   = 4'd2,
        OP_LOD   = 4'd3,
        OP_STO   = 4'd4,
        OP_CAL   = 4'd5,
        OP_INC   = 4'd6,
        OP_JMP   = 4'd7,
        OP_JPC   = 4'd8,
        OP_PRINT = 4'd9,
        OP_READ  = 4'd10,
        OP_HALT  = 4'd11
    } t_opcode;

    typedef enum logic [3:0] {
        FN_RET = 4'd0,
        FN_NEG = 4'd1,
        FN_ADD = 4'd2,
        FN_SUB = 4'd3,
        FN_MUL = 4'd4,
        FN_DIV = 4'd5,
        FN_ODD = 4'd6,
        FN_MOD = 4'd7,
        FN_EQ  = 4'd8,
        FN_NE  = 4'd9,
        FN_LT  = 4'd10,
        FN_LE  = 4'd11,
        FN_GT  = 4'd12,
        FN_GE  = 4'd13
    } t_alu_fn;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_OP   = 2'd1,
        ERR_DIV_ZERO = 2'd2,
        ERR_ADDR     = 2'd3
    } t_err;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_WALKW,
        S_ADDR,
        S_USE,
        S_RET1,
        S_RET2,
        S_OPA,
        S_OPB,
        S_DIV,
        S_DIVF,
        S_WB,
        S_CALW,
        S_DONE
    } t_state;

endpackage

[rtl/stack_machine_instruction_step.sv]
// Stack-machine instruction step: one p-code instruction per input transaction.
// Holds the stack memory, the machine registers and the instruction sequencer.
// Depends on smis_pkg for opcode, function, error and state encodings.
//
// Usage notes:
// The input channel (i_in_valid / o_in_stall) carries one instruction per
// transaction: opcode, static-link level, operand and the value pushed by a
// read instruction. The output channel (o_out_valid / i_out_stall) returns
// exactly one result transaction per instruction: the program counter, base
// pointer and stack pointer after the instruction, a printed value with its
// flag, the halt flag and an error code.
// After reset the block sweeps the stack memory to zero, one word per cycle;
// o_in_stall stays high during that sweep.
// Registers come out of reset as PC 0, BP 1, SP 0, not halted.
// Instructions run one at a time through a sequencer built around a single
// stack memory with one write port and one registered read port. Each
// static-link level adds one memory read and its return, loads, stores,
// prints and conditional jumps add states for their reads, a call adds a
// write state for each of its four frame writes, and divide or modulo run
// through the 32-step restoring divider.
// The result sits in an output register, so the next instruction is accepted
// while a result waits; if the receiver keeps stalling, the following result
// waits in the sequencer until the output register frees up.
// Once halted, every instruction returns the current registers with error 0.
module stack_machine_instruction_step #(
    parameter int STACK_DEPTH = 2048,
    parameter int CODE_DEPTH  = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [3:0]          i_opcode,
    input  logic [2:0]          i_level,
    input  logic signed [31:0]  i_operand,
    input  logic signed [31:0]  i_read_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [8:0]          o_next_pc,
    output logic [10:0]         o_frame_base,
    output logic [10:0]         o_stack_top,
    output logic signed [31:0]  o_print_value,
    output logic                o_print_valid,
    output logic                o_halted,
    output logic [1:0]          o_error_code
);

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(CODE_DEPTH);
    localparam int WW = smis_pkg::WORD_W;
    // Signed address arithmetic width: a stack index plus a 32-bit offset.
    localparam int AW = 34;
    localparam logic [SW:0] STK_LIM  = (SW+1)'(STACK_DEPTH);
    localparam logic [PW:0] CODE_LIM = (PW+1)'(CODE_DEPTH);

    function automatic logic [31:0] magn(input logic [31:0] a);
        magn = a[31] ? (32'd0 - a) : a;
    endfunction

    // Stack memory: one write port, one read port with registered data.
    logic [WW-1:0] mem [STACK_DEPTH];
    logic [WW-1:0] r_rdata;
    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;
    logic          mem_re;
    logic [SW-1:0] mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // Control registers.
    smis_pkg::t_state r_state, n_state;
    logic [SW-1:0] r_clr_idx, n_clr_idx;
    logic [PW-1:0] r_pc, n_pc;
    logic [SW-1:0] r_bp, n_bp;
    logic [SW-1:0] r_sp, n_sp;
    logic          r_halt, n_halt;
    logic          r_out_valid, n_out_valid;

    // Working registers of the current instruction.
    smis_pkg::t_opcode r_op, n_op;
    logic [2:0]    r_lvl, n_lvl;
    logic [31:0]   r_opnd, n_opnd;
    logic [31:0]   r_rval, n_rval;
    logic [31:0]   r_b, n_b;
    logic [31:0]   r_a, n_a;
    logic [31:0]   r_wb, n_wb;
    logic [31:0]   r_dvs, n_dvs;
    logic [31:0]   r_res, n_res;
    logic [31:0]   r_quo, n_quo;
    logic [31:0]   r_rem, n_rem;
    logic [4:0]    r_dcnt, n_dcnt;
    logic [1:0]    r_k, n_k;
    logic [31:0]   r_pv, n_pv;
    logic          r_pvalid, n_pvalid;
    smis_pkg::t_err r_err, n_err;

    // Output register.
    logic [smis_pkg::PC_OUT_W-1:0]  r_out_pc;
    logic [smis_pkg::PTR_OUT_W-1:0] r_out_bp;
    logic [smis_pkg::PTR_OUT_W-1:0] r_out_sp;
    logic [31:0]   r_out_pv;
    logic          r_out_pvalid;
    logic          r_out_halt;
    smis_pkg::t_err r_out_err;
    logic          load_out;

    // Address checks shared by several sequencer states.
    logic [PW:0]   pc1;
    logic          seq_ok;
    logic          tgt_ok;
    logic [SW:0]   sp_p1;
    logic [SW:0]   sp_p4;
    logic          sp_p1_ok;
    logic          sp_p4_ok;
    logic          sp_ge1;
    logic [AW-1:0] inc_sum;
    logic          inc_ok;
    logic [AW-1:0] fr_sum;
    logic          fr_ok;
    logic          ret_ok;
    logic          fn_ok;
    smis_pkg::t_alu_fn fn;
    logic [32:0]   div_sh;
    logic          div_ge;

    assign pc1      = {1'b0, r_pc} + 1'b1;
    assign seq_ok   = pc1 < CODE_LIM;
    assign tgt_ok   = !r_opnd[31] && (r_opnd < 32'(CODE_DEPTH));
    assign sp_p1    = {1'b0, r_sp} + 1'b1;
    assign sp_p4    = {1'b0, r_sp} + (SW+1)'(4);
    assign sp_p1_ok = sp_p1 < STK_LIM;
    assign sp_p4_ok = sp_p4 < STK_LIM;
    assign sp_ge1   = r_sp != '0;
    assign inc_sum  = {{(AW-SW){1'b0}}, r_sp} + {{(AW-32){r_opnd[31]}}, r_opnd};
    assign inc_ok   = !inc_sum[AW-1] && (inc_sum < AW'(STACK_DEPTH));
    assign fr_sum   = {{(AW-SW){1'b0}}, r_b[SW-1:0]} + {{(AW-32){r_opnd[31]}}, r_opnd};
    assign fr_ok    = !fr_sum[AW-1] && (fr_sum < AW'(STACK_DEPTH));
    assign ret_ok   = sp_ge1_bp() && (({1'b0, r_bp} + (SW+1)'(3)) < STK_LIM);
    assign fn_ok    = r_opnd < 32'(smis_pkg::ALU_FN_COUNT);
    assign fn       = smis_pkg::t_alu_fn'(r_opnd[3:0]);
    assign div_sh   = {r_rem, r_quo[31]};
    assign div_ge   = div_sh >= {1'b0, r_dvs};

    function automatic logic sp_ge1_bp();
        sp_ge1_bp = r_bp != '0;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smis_pkg::S_CLEAR;
            r_clr_idx   <= '0;
            r_pc        <= '0;
            r_bp        <= SW'(1);
            r_sp        <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_pc        <= n_pc;
            r_bp        <= n_bp;
            r_sp        <= n_sp;
            r_halt      <= n_halt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_lvl    <= n_lvl;
        r_opnd   <= n_opnd;
        r_rval   <= n_rval;
        r_b      <= n_b;
        r_a      <= n_a;
        r_wb     <= n_wb;
        r_dvs    <= n_dvs;
        r_res    <= n_res;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dcnt   <= n_dcnt;
        r_k      <= n_k;
        r_pv     <= n_pv;
        r_pvalid <= n_pvalid;
        r_err    <= n_err;
        if (load_out) begin
            r_out_pc     <= smis_pkg::PC_OUT_W'(r_pc);
            r_out_bp     <= smis_pkg::PTR_OUT_W'(r_bp);
            r_out_sp     <= smis_pkg::PTR_OUT_W'(r_sp);
            r_out_pv     <= r_pv;
            r_out_pvalid <= r_pvalid;
            r_out_halt   <= r_halt;
            r_out_err    <= r_err;
        end
    end

    // Sequencer: next state, register updates and memory port control.
    always_comb begin
        logic           fin;
        smis_pkg::t_err err;

        fin         = 1'b0;
        err         = smis_pkg::ERR_NONE;
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_pc        = r_pc;
        n_bp        = r_bp;
        n_sp        = r_sp;
        n_halt      = r_halt;
        n_out_valid = r_out_valid && i_out_stall;
        n_op        = r_op;
        n_lvl       = r_lvl;
        n_opnd      = r_opnd;
        n_rval      = r_rval;
        n_b         = r_b;
        n_a         = r_a;
        n_wb        = r_wb;
        n_dvs       = r_dvs;
        n_res       = r_res;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dcnt      = r_dcnt;
        n_k         = r_k;
        n_pv        = r_pv;
        n_pvalid    = r_pvalid;
        n_err       = r_err;
        load_out    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        unique case (r_state)
            smis_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                if (r_clr_idx == SW'(STACK_DEPTH - 1)) begin
                    n_state = smis_pkg::S_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            smis_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = smis_pkg::t_opcode'(i_opcode);
                    n_lvl    = i_level;
                    n_opnd   = i_operand;
                    n_rval   = i_read_value;
                    n_pv     = '0;
                    n_pvalid = 1'b0;
                    n_state  = smis_pkg::S_EXEC;
                end
            end
            smis_pkg::S_EXEC: begin
                if (r_halt) begin
                    fin = 1'b1;
                end else begin
                    unique case (r_op)
                        smis_pkg::OP_LIT, smis_pkg::OP_READ: begin
                            fin = 1'b1;
                            if (!seq_ok || !sp_p1_ok) begin
                                err = smis_pkg::ERR_ADDR;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = sp_p1[SW-1:0];
                                mem_wdata = (r_op == smis_pkg::OP_LIT) ? r_opnd : r_rval;
                                n_sp      = sp_p1[SW-1:0];
                                n_pc      = pc1[PW-1:0];
                            end
                        end
                        smis_pkg::OP_OPR: begin
                            priority if (!fn_ok) begin
                                fin = 1'b1;
                                err = smis_pkg::ERR_BAD_OP;
                            end else if (fn == smis_pkg::FN_RET) begin
                                if (!ret_ok) begin
                                    fin = 1'b1;
                                    err = smis_pkg::ERR_ADDR;
                                end else begin
                                    mem_re    = 1'b1;
                                    mem_raddr = r_bp + SW'(3);
                                    n_state   = smis_pkg::S_RET1;
                                end
                            end else if (!seq_ok) begin
                                fin = 1'b1;
                                err = smis_pkg::ERR_ADDR;
                            end else if (fn == smis_pkg::FN_NEG || fn == smis_pkg::FN_ODD) begin
                                mem_re    = 1'b1;
                                mem_raddr = r_sp;
                                n_state   = smis_pkg::S_USE;
                            end else if (!sp_ge1) begin
                                fin = 1'b1;
                                err = smis_pkg::ERR_ADDR;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_sp - 1'b1;
                                n_state   = smis_pkg::S_OPA;
                            end
                        end
                        smis_pkg::OP_LOD, smis_pkg::OP_STO, smis_pkg::OP_CAL: begin
                            n_b     = 32'(r_bp);
                            n_state = smis_pkg::S_WALK;
                        end
                        smis_pkg::OP_INC: begin
                            fin = 1'b1;
                            if (!seq_ok || !inc_ok) begin
                                err = smis_pkg::ERR_ADDR;
                            end else begin
                                n_sp = inc_sum[SW-1:0];
                                n_pc = pc1[PW-1:0];
                            end
                        end
                        smis_pkg::OP_JMP: begin
                            fin = 1'b1;
                            if (!tgt_ok) begin
                                err = smis_pkg::ERR_ADDR;
                            end else begin
                                n_pc = r_opnd[PW-1:0];
                            end
                        end
                        smis_pkg::OP_JPC, smis_pkg::OP_PRINT: begin
                            if (!sp_ge1 || (r_op == smis_pkg::OP_PRINT && !seq_ok)) begin
                                fin = 1'b1;
                                err = smis_pkg::ERR_ADDR;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_sp;
                                n_state   = smis_pkg::S_USE;
                            end
                        end
                        smis_pkg::OP_HALT: begin
                            fin    = 1'b1;
                            n_halt = 1'b1;
                            n_pc   = '0;
                            n_bp   = '0;
                            n_sp   = '0;
                        end
                        default: begin
                            fin = 1'b1;
                            err = smis_pkg::ERR_BAD_OP;
                        end
                    endcase
                end
            end
            smis_pkg::S_WALK: begin
                // Follow the static link one level per read.
                if (r_lvl == 3'd0) begin
                    if (r_b < 32'(STACK_DEPTH)) begin
                        n_state = smis_pkg::S_ADDR;
                    end else begin
                        fin = 1'b1;
                        err = smis_pkg::ERR_ADDR;
                    end
                end else if (r_b >= 32'(STACK_DEPTH - 1)) begin
                    fin = 1'b1;
                    err = smis_pkg::ERR_ADDR;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_b[SW-1:0] + 1'b1;
                    n_lvl     = r_lvl - 1'b1;
                    n_state   = smis_pkg::S_WALKW;
                end
            end
            smis_pkg::S_WALKW: begin
                n_b     = r_rdata;
                n_state = smis_pkg::S_WALK;
            end
            smis_pkg::S_ADDR: begin
                unique case (r_op)
                    smis_pkg::OP_LOD: begin
                        if (!seq_ok || !fr_ok || !sp_p1_ok) begin
                            fin = 1'b1;
                            err = smis_pkg::ERR_ADDR;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = fr_sum[SW-1:0];
                            n_state   = smis_pkg::S_USE;
                        end
                    end
                    smis_pkg::OP_STO: begin
                        if (!seq_ok || !fr_ok || !sp_ge1) begin
                            fin = 1'b1;
                            err = smis_pkg::ERR_ADDR;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = r_sp;
                            n_state   = smis_pkg::S_USE;
                        end
                    end
                    default: begin
                        if (!sp_p4_ok || !tgt_ok) begin
                            fin = 1'b1;
                            err = smis_pkg::ERR_ADDR;
                        end else begin
                            n_k     = 2'd0;
                            n_state = smis_pkg::S_CALW;
                        end
                    end
                endcase
            end
            smis_pkg::S_USE: begin
                fin = 1'b1;
                unique case (r_op)
                    smis_pkg::OP_PRINT: begin
                        n_pv     = r_rdata;
                        n_pvalid = 1'b1;
                        n_sp     = r_sp - 1'b1;
                        n_pc     = pc1[PW-1:0];
                    end
                    smis_pkg::OP_JPC: begin
                        if (r_rdata == '0) begin
                            if (!tgt_ok) begin
                                err = smis_pkg::ERR_ADDR;
                            end else begin
                                n_pc = r_opnd[PW-1:0];
                                n_sp = r_sp - 1'b1;
                            end
                        end else if (!seq_ok) begin
                            err = smis_pkg::ERR_ADDR;
                        end else begin
                            n_pc = pc1[PW-1:0];
                            n_sp = r_sp - 1'b1;
                        end
                    end
                    smis_pkg::OP_LOD: begin
                        mem_we    = 1'b1;
                        mem_waddr = sp_p1[SW-1:0];
                        mem_wdata = r_rdata;
                        n_sp      = sp_p1[SW-1:0];
                        n_pc      = pc1[PW-1:0];
                    end
                    smis_pkg::OP_STO: begin
                        mem_we    = 1'b1;
                        mem_waddr = fr_sum[SW-1:0];
                        mem_wdata = r_rdata;
                        n_sp      = r_sp - 1'b1;
                        n_pc      = pc1[PW-1:0];
                    end
                    default: begin
                        // Negate or odd, in place on the top of stack.
                        mem_we    = 1'b1;
                        mem_waddr = r_sp;
                        mem_wdata = (fn == smis_pkg::FN_NEG) ? (32'd0 - r_rdata)
                                                             : {31'd0, r_rdata[0]};
                        n_pc      = pc1[PW-1:0];
                    end
                endcase
            end
            smis_pkg::S_RET1: begin
                n_a       = r_rdata;
                mem_re    = 1'b1;
                mem_raddr = r_bp + SW'(2);
                n_state   = smis_pkg::S_RET2;
            end
            smis_pkg::S_RET2: begin
                fin = 1'b1;
                if (r_a >= 32'(CODE_DEPTH) || r_rdata >= 32'(STACK_DEPTH)) begin
                    err = smis_pkg::ERR_ADDR;
                end else begin
                    n_sp = r_bp - 1'b1;
                    n_pc = r_a[PW-1:0];
                    n_bp = r_rdata[SW-1:0];
                end
            end
            smis_pkg::S_OPA: begin
                n_a       = r_rdata;
                mem_re    = 1'b1;
                mem_raddr = r_sp;
                n_state   = smis_pkg::S_OPB;
            end
            smis_pkg::S_OPB: begin
                n_state = smis_pkg::S_WB;
                unique case (fn)
                    smis_pkg::FN_DIV, smis_pkg::FN_MOD: begin
                        if (r_rdata == '0) begin
                            fin = 1'b1;
                            err = smis_pkg::ERR_DIV_ZERO;
                        end else begin
                            n_quo   = magn(r_a);
                            n_rem   = '0;
                            n_dvs   = magn(r_rdata);
                            n_wb    = r_rdata;
                            n_dcnt  = '0;
                            n_state = smis_pkg::S_DIV;
                        end
                    end
                    smis_pkg::FN_ADD: n_res = r_a + r_rdata;
                    smis_pkg::FN_SUB: n_res = r_a - r_rdata;
                    smis_pkg::FN_MUL: n_res = r_a * r_rdata;
                    smis_pkg::FN_EQ:  n_res = 32'(r_a == r_rdata);
                    smis_pkg::FN_NE:  n_res = 32'(r_a != r_rdata);
                    smis_pkg::FN_LT:  n_res = 32'($signed(r_a) < $signed(r_rdata));
                    smis_pkg::FN_LE:  n_res = 32'($signed(r_a) <= $signed(r_rdata));
                    smis_pkg::FN_GT:  n_res = 32'($signed(r_a) > $signed(r_rdata));
                    smis_pkg::FN_GE:  n_res = 32'($signed(r_a) >= $signed(r_rdata));
                    default:          n_res = '0;
                endcase
            end
            smis_pkg::S_DIV: begin
                // One restoring step per cycle on the magnitudes.
                if (div_ge) begin
                    n_rem = 32'(div_sh - {1'b0, r_dvs});
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = div_sh[31:0];
                    n_quo = {r_quo[30:0], 1'b0};
                end
                if (r_dcnt == 5'(WW - 1)) begin
                    n_state = smis_pkg::S_DIVF;
                end else begin
                    n_dcnt = r_dcnt + 1'b1;
                end
            end
            smis_pkg::S_DIVF: begin
                if (fn == smis_pkg::FN_DIV) begin
                    n_res = (r_a[31] ^ r_wb[31]) ? (32'd0 - r_quo) : r_quo;
                end else begin
                    n_res = r_a[31] ? (32'd0 - r_rem) : r_rem;
                end
                n_state = smis_pkg::S_WB;
            end
            smis_pkg::S_WB: begin
                fin       = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = r_sp - 1'b1;
                mem_wdata = r_res;
                n_sp      = r_sp - 1'b1;
                n_pc      = pc1[PW-1:0];
            end
            smis_pkg::S_CALW: begin
                // Frame words: functional value, static link, dynamic link, return.
                mem_we    = 1'b1;
                mem_waddr = sp_p1[SW-1:0] + SW'(r_k);
                unique case (r_k)
                    2'd0: mem_wdata = '0;
                    2'd1: mem_wdata = r_b;
                    2'd2: mem_wdata = 32'(r_bp);
                    2'd3: mem_wdata = 32'(pc1);
                endcase
                if (r_k == 2'd3) begin
                    fin  = 1'b1;
                    n_bp = sp_p1[SW-1:0];
                    n_pc = r_opnd[PW-1:0];
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            smis_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = smis_pkg::S_IDLE;
                end
            end
        endcase

        // An error leaves the registers as they were and stops the machine.
        if (fin) begin
            n_state = smis_pkg::S_DONE;
            n_err   = err;
            if (err != smis_pkg::ERR_NONE) begin
                n_halt   = 1'b1;
                n_pc     = r_pc;
                n_bp     = r_bp;
                n_sp     = r_sp;
                n_pv     = '0;
                n_pvalid = 1'b0;
            end
        end
    end

    assign o_in_stall    = r_state != smis_pkg::S_IDLE;
    assign o_out_valid   = r_out_valid;
    assign o_next_pc     = r_out_pc;
    assign o_frame_base  = r_out_bp;
    assign o_stack_top   = r_out_sp;
    assign o_print_value = r_out_pv;
    assign o_print_valid = r_out_pvalid;
    assign o_halted      = r_out_halt;
    assign o_error_code  = r_out_err;

`ifndef SYNTHESIS
    // Only reset may clear the halt flag.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag dropped without reset");

    // A result that reports an error also reports a halted machine.
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code != smis_pkg::ERR_NONE) |-> o_halted)
        else $error("error result without halt");

    // A printed value never comes with an error.
    a_print_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_print_valid) |-> (o_error_code == smis_pkg::ERR_NONE))
        else $error("print result carries an error");

    // The stack and base pointers always address the stack memory.
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_sp} < STK_LIM) && ({1'b0, r_bp} < STK_LIM))
        else $error("stack or base pointer out of range");

    // The memory is never written while waiting for an instruction.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smis_pkg::S_IDLE) |-> !mem_we)
        else $error("stack write while idle");
`endif

endmodule
